[hdl/hrfl_pkg.sv]
// Shared types and constants for the HEX record flash loader.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package hrfl_pkg;

  localparam int STORE_BYTES = 32;
  localparam int IDX_W       = 5;
  localparam int CNT_W       = 6;
  localparam logic [7:0] MAX_LEN = 8'd25;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;
  localparam logic [7:0] REC_EXT  = 8'h04;
  localparam logic [7:0] PAD_BYTE = 8'hFF;
  localparam logic [7:0] DW_BYTES = 8'h08;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_NACK  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIN,
    ST_FLUSH,
    ST_FLUSH_EOF,
    ST_ACK,
    ST_ACK_DONE,
    ST_NACK
  } state_t;

  typedef struct packed {
    logic take;
    logic commit;
    logic set_ext;
    logic pad;
    logic emit_write;
    logic emit_ack;
    logic emit_nack;
    logic done_flag;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic       timeout_nack;
    logic       completes;
    logic       sum_ok;
    logic [7:0] rec_type;
    logic       count_nz;
    logic       can_flush;
    logic       out_free;
  } status_t;

endpackage

[hdl/hrfl_ctrl.sv]
// Controller state machine of the HEX record flash loader.
// Depends on hrfl_pkg; drives the datapath through cmd_t and reads status_t.
`timescale 1ns / 1ps
module hrfl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hrfl_pkg::status_t st,
  output hrfl_pkg::cmd_t    cmd
);
  import hrfl_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (st.timeout_nack) begin
            state_nxt = ST_NACK;
          end else if (st.completes) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!st.sum_ok) begin
          state_nxt = ST_NACK;
        end else if (st.rec_type == REC_DATA) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_FLUSH;
        end else if (st.rec_type == REC_EXT) begin
          cmd.set_ext = 1'b1;
          state_nxt   = ST_ACK;
        end else if (st.rec_type == REC_EOF) begin
          if (st.count_nz) begin
            cmd.pad   = 1'b1;
            state_nxt = ST_FLUSH_EOF;
          end else begin
            state_nxt = ST_ACK_DONE;
          end
        end else begin
          state_nxt = ST_ACK;
        end
      end
      ST_FLUSH, ST_FLUSH_EOF: begin
        if (st.can_flush) begin
          if (st.out_free) begin
            cmd.emit_write = 1'b1;
          end
        end else begin
          state_nxt = (state_r == ST_FLUSH_EOF) ? ST_ACK_DONE : ST_ACK;
        end
      end
      ST_ACK: begin
        if (st.out_free) begin
          cmd.emit_ack = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_ACK_DONE: begin
        if (st.out_free) begin
          cmd.emit_ack  = 1'b1;
          cmd.done_flag = 1'b1;
          cmd.clear     = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_NACK: begin
        if (st.out_free) begin
          cmd.emit_nack = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/hrfl_dp.sv]
// Datapath of the HEX record flash loader: record parsing, pending store,
// address registers and the output register. Depends on hrfl_pkg.
`timescale 1ns / 1ps
module hrfl_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  hrfl_pkg::cmd_t    cmd,
  output hrfl_pkg::status_t st,
  input  logic [7:0]        in_rx_byte,
  input  logic              in_is_timeout,
  input  logic              cfg_valid,
  input  logic [31:0]       cfg_erased_limit,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_reply_kind,
  output logic [31:0]       out_flash_address,
  output logic [63:0]       out_flash_data,
  output logic              out_session_done,
  output logic              out_last
);
  import hrfl_pkg::*;

  logic [4:0]  pos_r, pos_nxt;
  logic        overlong_r, overlong_nxt;
  logic [7:0]  len_r, ah_r, al_r, type_r, b4_r, b5_r, sum_r;
  logic [15:0] ext_r, ext_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [31:0] limit_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]  store_r [STORE_BYTES];
  logic [7:0]  store_nxt [STORE_BYTES];
  logic        ov_r;
  logic [1:0]  kind_r;
  logic [31:0] oaddr_r;
  logic [63:0] odata_r;
  logic        odone_r, olast_r;

  logic        byte_path;
  logic [8:0]  rec_total;
  logic [6:0]  wr_idx;
  logic [6:0]  round_up;
  logic [6:0]  commit_sum;
  logic [CNT_W-1:0] pad_end;
  logic [63:0] dword;
  logic        load;

  assign byte_path  = cmd.take && !in_is_timeout && !overlong_r && (pos_r != 5'd0);
  assign rec_total  = {1'b0, len_r} + 9'd5;
  assign wr_idx     = {1'b0, count_r} + {2'b00, pos_r} - 7'd4;
  assign round_up   = ({1'b0, count_r} + 7'd7) & ~7'd7;
  assign pad_end    = (round_up > 7'(STORE_BYTES)) ? CNT_W'(STORE_BYTES) : round_up[CNT_W-1:0];
  assign commit_sum = {1'b0, count_r} + len_r[6:0];

  always_comb begin
    dword = '0;
    for (int b = 0; b < 8; b++) begin
      dword[b*8 +: 8] = store_r[b];
    end
  end

  always_comb begin
    st.timeout_nack = in_is_timeout && ((pos_r != 5'd0) || overlong_r);
    st.completes    = !in_is_timeout && !overlong_r && (pos_r != 5'd0) &&
                      ({4'd0, pos_r} + 9'd1 >= rec_total);
    st.sum_ok       = (sum_r == 8'd0);
    st.rec_type     = type_r;
    st.count_nz     = (count_r != '0);
    st.can_flush    = (count_r >= CNT_W'(DW_BYTES)) &&
                      ({1'b0, addr_r} + 33'({DW_BYTES}) < {1'b0, limit_r});
    st.out_free     = !ov_r || out_ready;
  end

  always_comb begin
    pos_nxt      = pos_r;
    overlong_nxt = overlong_r;
    ext_nxt      = ext_r;
    addr_nxt     = addr_r;
    count_nxt    = count_r;
    for (int i = 0; i < STORE_BYTES; i++) begin
      store_nxt[i] = store_r[i];
    end
    if (cmd.take) begin
      if (in_is_timeout) begin
        pos_nxt      = 5'd0;
        overlong_nxt = 1'b0;
      end else if (!overlong_r) begin
        if (pos_r == 5'd0) begin
          if (in_rx_byte > MAX_LEN) begin
            overlong_nxt = 1'b1;
          end else begin
            pos_nxt = 5'd1;
          end
        end else if (st.completes) begin
          pos_nxt = 5'd0;
        end else begin
          pos_nxt = pos_r + 5'd1;
        end
      end
    end
    if (byte_path && pos_r >= 5'd4 && wr_idx < 7'(STORE_BYTES)) begin
      store_nxt[wr_idx[IDX_W-1:0]] = in_rx_byte;
    end
    if (cmd.commit) begin
      if (count_r == '0) begin
        addr_nxt = {ext_r, ah_r, al_r};
      end
      count_nxt = (commit_sum > 7'(STORE_BYTES)) ? CNT_W'(STORE_BYTES) : commit_sum[CNT_W-1:0];
    end
    if (cmd.set_ext) begin
      ext_nxt = {b4_r, b5_r};
    end
    if (cmd.pad) begin
      for (int i = 0; i < STORE_BYTES; i++) begin
        if (CNT_W'(i) >= count_r && CNT_W'(i) < pad_end) begin
          store_nxt[i] = PAD_BYTE;
        end
      end
      count_nxt = pad_end;
    end
    if (cmd.emit_write) begin
      for (int i = 0; i < STORE_BYTES - 8; i++) begin
        store_nxt[i] = store_r[i+8];
      end
      count_nxt = count_r - CNT_W'(DW_BYTES);
      addr_nxt  = addr_r + 32'(DW_BYTES);
    end
    if (cmd.clear) begin
      pos_nxt      = 5'd0;
      overlong_nxt = 1'b0;
      ext_nxt      = '0;
      addr_nxt     = '0;
      count_nxt    = '0;
    end
  end

  assign load = cmd.emit_write || cmd.emit_ack || cmd.emit_nack;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      overlong_r <= 1'b0;
      ext_r      <= '0;
      addr_r     <= '0;
      count_r    <= '0;
      limit_r    <= '0;
      ov_r       <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      overlong_r <= overlong_nxt;
      ext_r      <= ext_nxt;
      addr_r     <= addr_nxt;
      count_r    <= count_nxt;
      if (cfg_valid) begin
        limit_r <= cfg_erased_limit;
      end
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STORE_BYTES; i++) begin
      store_r[i] <= store_nxt[i];
    end
    if (cmd.take && !in_is_timeout && !overlong_r) begin
      if (pos_r == 5'd0) begin
        len_r <= in_rx_byte;
        sum_r <= in_rx_byte;
      end else begin
        sum_r <= sum_r + in_rx_byte;
        case (pos_r)
          5'd1:    ah_r   <= in_rx_byte;
          5'd2:    al_r   <= in_rx_byte;
          5'd3:    type_r <= in_rx_byte;
          5'd4:    b4_r   <= in_rx_byte;
          5'd5:    b5_r   <= in_rx_byte;
          default: ;
        endcase
      end
    end
    if (load) begin
      kind_r  <= cmd.emit_write ? KIND_WRITE : (cmd.emit_ack ? KIND_ACK : KIND_NACK);
      oaddr_r <= cmd.emit_write ? addr_r : 32'd0;
      odata_r <= cmd.emit_write ? dword : 64'd0;
      odone_r <= cmd.done_flag;
      olast_r <= !cmd.emit_write;
    end
  end

  assign out_valid         = ov_r;
  assign out_reply_kind    = kind_r;
  assign out_flash_address = oaddr_r;
  assign out_flash_data    = odata_r;
  assign out_session_done  = odone_r;
  assign out_last          = olast_r;

endmodule

[hdl/hex_record_flash_loader.sv]
// HEX record flash loader, top level.
// Received bytes enter on the in_ channel, one word per byte or timeout event.
// in_is_timeout marks an inter-byte timeout; in_rx_byte is then ignored.
// Each completed record yields zero or more flash doubleword writes and then
// one ACK or NACK word on the out_ channel; out_last marks that final word.
// A timeout in mid-record yields a single NACK; an idle timeout yields nothing.
// A byte is taken only while the controller is idle. A completed
// record passes through decoding, one flush step per flash write, leaving
// the flush and the reply, after which the input is ready again; an output
// stall can hold the flush and reply steps.
// The output register lets a new byte be taken while the last result waits.
// When the receiver stalls, the controller holds in its flush or reply state.
// cfg_erased_limit is written whenever cfg_valid is high; cfg_ready is always
// high. Writes go only while address + 8 is below the limit.
// Synchronous reset clears the session, the limit and the output register.
// Depends on hrfl_pkg, hrfl_ctrl and hrfl_dp.
`timescale 1ns / 1ps
module hex_record_flash_loader (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_is_timeout,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_reply_kind,
  output logic [31:0] out_flash_address,
  output logic [63:0] out_flash_data,
  output logic        out_session_done,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_erased_limit
);
  import hrfl_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  hrfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  hrfl_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_rx_byte        (in_rx_byte),
    .in_is_timeout     (in_is_timeout),
    .cfg_valid         (cfg_valid),
    .cfg_erased_limit  (cfg_erased_limit),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reply_kind    (out_reply_kind),
    .out_flash_address (out_flash_address),
    .out_flash_data    (out_flash_data),
    .out_session_done  (out_session_done),
    .out_last          (out_last)
  );

endmodule

[verif/hrfl_reply_checker.sv]
// Reply checker for the HEX record flash loader: watches the in_, out_ and cfg_ channels,
// predicts every reply word and compares it field by field. Depends on hrfl_pkg.
`timescale 1ns / 1ps
module hrfl_reply_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_is_timeout,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_reply_kind,
  input  logic [31:0] out_flash_address,
  input  logic [63:0] out_flash_data,
  input  logic        out_session_done,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_erased_limit,
  output int          mismatches,
  output int          outstanding,
  output int          replies_seen,
  output int          flash_writes_seen
);
  import hrfl_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [63:0] data;
    logic        done;
    logic        last;
  } reply_t;

  reply_t      expected_replies[$];
  logic [7:0]  rec_buf[30];
  int          rec_pos;
  logic        rec_long;
  logic [15:0] ext_addr;
  logic [31:0] wr_addr;
  logic [7:0]  store[STORE_BYTES];
  int          store_cnt;
  logic [31:0] limit;

  task automatic add_reply(input logic [1:0] kind, input logic [31:0] addr,
                           input logic [63:0] data, input logic done);
    reply_t r;
    r = '{kind: kind, addr: addr, data: data, done: done, last: 1'b0};
    expected_replies.push_back(r);
  endtask

  task automatic flush_store();
    int off;
    logic [63:0] dw;
    off = 0;
    while (store_cnt - off >= 8 && ({1'b0, wr_addr} + 33'd8) < {1'b0, limit}) begin
      dw = '0;
      for (int b = 7; b >= 0; b--) dw = {dw[55:0], store[off + b]};
      add_reply(KIND_WRITE, wr_addr, dw, 1'b0);
      wr_addr += 32'd8;
      off += 8;
    end
    if (off > 0) begin
      for (int i = 0; i < store_cnt - off; i++) store[i] = store[i + off];
      store_cnt -= off;
    end
  endtask

  task automatic predict_replies(input logic [7:0] b, input logic tmo);
    int n0;
    int len;
    logic [7:0] sum;
    logic done;
    reply_t r;
    n0 = expected_replies.size();
    if (tmo) begin
      if (rec_pos != 0 || rec_long) begin
        rec_pos = 0;
        rec_long = 1'b0;
        add_reply(KIND_NACK, '0, '0, 1'b0);
      end
    end else if (rec_long) begin
    end else if (rec_pos == 0) begin
      rec_buf[0] = b;
      if (b > MAX_LEN) rec_long = 1'b1;
      else rec_pos = 1;
    end else begin
      rec_buf[rec_pos] = b;
      rec_pos++;
      len = rec_buf[0];
      if (rec_pos >= len + 5) begin
        sum = '0;
        for (int i = 0; i < len + 5; i++) sum += rec_buf[i];
        rec_pos = 0;
        if (sum != 8'd0) begin
          add_reply(KIND_NACK, '0, '0, 1'b0);
        end else begin
          done = 1'b0;
          case (rec_buf[3])
            REC_EXT: ext_addr = {rec_buf[4], rec_buf[5]};
            REC_DATA: begin
              if (store_cnt == 0) wr_addr = {ext_addr, rec_buf[1], rec_buf[2]};
              for (int i = 0; i < len; i++) begin
                if (store_cnt < STORE_BYTES) begin
                  store[store_cnt] = rec_buf[4 + i];
                  store_cnt++;
                end
              end
              if (store_cnt >= 8) flush_store();
            end
            REC_EOF: begin
              if (store_cnt > 0) begin
                while (store_cnt % 8 != 0 && store_cnt < STORE_BYTES) begin
                  store[store_cnt] = PAD_BYTE;
                  store_cnt++;
                end
                flush_store();
              end
              rec_long = 1'b0;
              ext_addr = '0;
              wr_addr = '0;
              store_cnt = 0;
              done = 1'b1;
            end
            default: ;
          endcase
          add_reply(KIND_ACK, '0, '0, done);
        end
      end
    end
    if (expected_replies.size() > n0) begin
      r = expected_replies.pop_back();
      r.last = 1'b1;
      expected_replies.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    reply_t e;
    if (!rst_n) begin
      expected_replies.delete();
      rec_pos = 0;
      rec_long = 1'b0;
      ext_addr = '0;
      wr_addr = '0;
      store_cnt = 0;
      limit = '0;
      mismatches = 0;
      replies_seen = 0;
      flash_writes_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) limit = cfg_erased_limit;
      if (out_valid && out_ready) begin
        replies_seen++;
        if (out_reply_kind == KIND_WRITE) flash_writes_seen++;
        if (expected_replies.size() == 0) begin
          $error("Reply word with nothing expected, kind %0d", out_reply_kind);
          mismatches++;
        end else begin
          e = expected_replies.pop_front();
          if (out_reply_kind !== e.kind) begin
            $error("reply_kind expected %0d actual %0d", e.kind, out_reply_kind);
            mismatches++;
          end
          if (out_flash_address !== e.addr) begin
            $error("flash_address expected %h actual %h", e.addr, out_flash_address);
            mismatches++;
          end
          if (out_flash_data !== e.data) begin
            $error("flash_data expected %h actual %h", e.data, out_flash_data);
            mismatches++;
          end
          if (out_session_done !== e.done) begin
            $error("session_done expected %0d actual %0d", e.done, out_session_done);
            mismatches++;
          end
          if (out_last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, out_last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) predict_replies(in_rx_byte, in_is_timeout);
    end
    outstanding = expected_replies.size();
  end

endmodule

[verif/hex_record_flash_loader_tb.sv]
// Testbench top for the HEX record flash loader: drives records, timeouts and limit
// settings, stalls the receiver and gives the verdict. Depends on hrfl_pkg,
// hrfl_reply_checker and the loader RTL.
`timescale 1ns / 1ps
module hex_record_flash_loader_tb;
  import hrfl_pkg::*;

  localparam int TARGET_WORDS = 470;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        in_is_timeout;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_reply_kind;
  logic [31:0] out_flash_address;
  logic [63:0] out_flash_data;
  logic        out_session_done;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_erased_limit;
  int          mismatches;
  int          outstanding;
  int          replies_seen;
  int          flash_writes_seen;
  int          words_sent;
  int          records_sent;
  bit          hold_req;

  hex_record_flash_loader u_top (.*);

  hrfl_reply_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int r;
    int dur;
    out_ready = 1'b0;
    hold_req = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ready <= 1'b1;
          dur = $urandom_range(1, 20);
        end else if (r < 95) begin
          out_ready <= 1'b0;
          dur = $urandom_range(1, 4);
        end else begin
          out_ready <= 1'b0;
          dur = $urandom_range(20, 80);
        end
        repeat (dur - 1) @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic tmo);
    logic took;
    int r;
    int gap;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_is_timeout <= tmo;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end
    words_sent++;
    r = $urandom_range(0, 99);
    if (r < 60) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_record(input logic [7:0] kind, input logic [15:0] addr,
                             input int len, input bit corrupt);
    logic [7:0] body[$];
    logic [7:0] sum;
    bit zero_fill;
    zero_fill = (kind == REC_EXT) && ($urandom_range(0, 1) == 1);
    body = {len[7:0], addr[15:8], addr[7:0], kind};
    repeat (len) body.push_back(zero_fill ? 8'h00 : 8'($urandom_range(0, 255)));
    sum = '0;
    foreach (body[i]) sum += body[i];
    sum = -sum;
    if (corrupt) sum += 8'($urandom_range(1, 255));
    body.push_back(sum);
    records_sent++;
    foreach (body[i]) send_word(body[i], 1'b0);
  endtask

  task automatic send_timeout();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    logic took;
    cfg_valid <= 1'b1;
    cfg_erased_limit <= v;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_record();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_record(REC_DATA, 16'($urandom_range(0, 'h80)), $urandom_range(0, 25), 1'b0);
    end else if (r < 55) begin
      send_record(REC_EXT, 16'($urandom), ($urandom_range(0, 5) == 0) ?
                  $urandom_range(0, 1) : $urandom_range(2, 4), 1'b0);
    end else if (r < 62) begin
      send_record(REC_EOF, 16'($urandom), $urandom_range(0, 2), 1'b0);
    end else if (r < 67) begin
      send_record(8'($urandom_range(2, 255)), 16'($urandom), $urandom_range(0, 25), 1'b0);
    end else if (r < 75) begin
      send_record(8'($urandom_range(0, 5)), 16'($urandom), $urandom_range(0, 25), 1'b1);
    end else if (r < 82) begin
      send_word(8'($urandom_range(1, 25)), 1'b0);
      repeat ($urandom_range(0, 6)) send_word(8'($urandom), 1'b0);
      send_timeout();
    end else if (r < 88) begin
      send_word(8'($urandom_range(26, 255)), 1'b0);
      repeat ($urandom_range(0, 8)) send_word(8'($urandom), 1'b0);
      send_timeout();
    end else if (r < 93) begin
      send_timeout();
    end else begin
      repeat ($urandom_range(1, 10)) send_word(8'($urandom), 1'b0);
      send_timeout();
    end
  endtask

  initial begin
    logic [31:0] limits[4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    in_is_timeout = 1'b0;
    cfg_valid = 1'b0;
    cfg_erased_limit = '0;
    words_sent = 0;
    records_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_limit(32'hFFFF_FFFF);
    send_record(REC_EXT, 16'h0000, 2, 1'b0);
    send_timeout();
    send_record(REC_DATA, 16'h0010, 0, 1'b0);
    send_record(REC_DATA, 16'h0010, 25, 1'b0);
    send_record(REC_DATA, 16'h0029, 20, 1'b0);
    send_record(REC_DATA, 16'h0040, 4, 1'b1);
    send_record(REC_EXT, 16'h0000, 0, 1'b0);
    send_record(8'h05, 16'h0000, 4, 1'b0);
    send_record(8'h7E, 16'h1234, 1, 1'b0);
    send_word(8'd3, 1'b0);
    send_word(8'hAA, 1'b0);
    send_timeout();
    send_word(8'hFF, 1'b0);
    send_word(8'h55, 1'b0);
    send_timeout();
    send_record(REC_DATA, 16'hFFF0, 13, 1'b0);
    send_record(REC_EOF, 16'h0000, 0, 1'b0);
    settle();

    limits = '{32'h0000_0000, 32'h0000_0048, 32'($urandom), 32'hFFFF_FFFF};
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(limits[ph]);
      if (ph == 3) begin
        hold_req = 1'b1;
        repeat (4) send_record(REC_DATA, 16'($urandom_range(0, 'h40)), 25, 1'b0);
      end
      while (words_sent < TARGET_WORDS * (ph + 1) / 4) random_record();
      send_record(REC_EOF, 16'h0000, 0, 1'b0);
      settle();
    end

    $display("Sent %0d input words in %0d records with timeouts and noise, four limit settings.",
             words_sent, records_sent);
    $display("Checked %0d reply words, %0d of them flash writes.",
             replies_seen, flash_writes_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/hrfl_pkg.sv
hdl/hrfl_ctrl.sv
hdl/hrfl_dp.sv
hdl/hex_record_flash_loader.sv
verif/hrfl_reply_checker.sv
verif/hex_record_flash_loader_tb.sv
